>>> rtl/syrpf_pkg.sv
// Shared types, register codes and small arithmetic helpers for the scaled
// pixel fetch core. No dependencies.
package syrpf_pkg;

    typedef struct packed {
        logic        command;
        logic [19:0] store_address;
        logic [15:0] write_data;
        logic [11:0] dest_x;
        logic [11:0] dest_y;
    } t_item;

    typedef struct packed {
        logic [11:0] source_width;
        logic [11:0] source_height;
        logic [11:0] dest_width;
        logic [11:0] dest_height;
        logic [13:0] source_stride;
        logic [1:0]  source_format;
        logic        dest_bpp_mode;
    } t_cfg;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [1:0] FMT_RGB565 = 2'd0;
    localparam logic [1:0] FMT_YUYV   = 2'd1;
    localparam logic [1:0] FMT_UYVY   = 2'd2;

    localparam logic BPP_RGB565 = 1'b0;

    localparam logic [2:0] REG_SOURCE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SOURCE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_DEST_WIDTH    = 3'd2;
    localparam logic [2:0] REG_DEST_HEIGHT   = 3'd3;
    localparam logic [2:0] REG_SOURCE_STRIDE = 3'd4;
    localparam logic [2:0] REG_SOURCE_FORMAT = 3'd5;
    localparam logic [2:0] REG_DEST_BPP_MODE = 3'd6;

    localparam t_cfg CFG_RESET = '{
        source_width:  12'd1024,
        source_height: 12'd600,
        dest_width:    12'd1024,
        dest_height:   12'd600,
        source_stride: 14'd1024,
        source_format: FMT_YUYV,
        dest_bpp_mode: BPP_RGB565
    };

    function automatic logic [11:0] at_least_one(input logic [11:0] v);
        return (v == 12'd0) ? 12'd1 : v;
    endfunction

    // Floor of the sum over 256, limited to 0..255.
    function automatic logic [7:0] clamp8(input logic signed [19:0] s);
        logic [11:0] t;
        t = s[19:8];
        if (s < 0) begin
            return 8'd0;
        end
        return (t > 12'd255) ? 8'd255 : t[7:0];
    endfunction

    // floor(v*255/31) by reciprocal multiply and one correction.
    function automatic logic [7:0] widen5(input logic [4:0] v);
        logic [12:0] n;
        logic [17:0] p;
        logic [7:0]  q;
        logic [12:0] r;
        n = 13'(v) * 13'd255;
        p = 18'(n) * 18'd33;
        q = p[17:10];
        r = n - 13'(q) * 13'd31;
        return (r >= 13'd31) ? q + 8'd1 : q;
    endfunction

    // floor(v*255/63) by reciprocal multiply and one correction.
    function automatic logic [7:0] widen6(input logic [5:0] v);
        logic [13:0] n;
        logic [20:0] p;
        logic [7:0]  q;
        logic [13:0] r;
        n = 14'(v) * 14'd255;
        p = 21'(n) * 21'd65;
        q = p[19:12];
        r = n - 14'(q) * 14'd63;
        return (r >= 14'd63) ? q + 8'd1 : q;
    endfunction

endpackage

>>> rtl/syrpf_front.sv
// Front end: takes commands and holds them in a two-entry queue for the
// back end. Depends on syrpf_pkg.
module syrpf_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  syrpf_pkg::t_item    i_item,
    output logic                o_full,
    output logic                o_avail,
    output syrpf_pkg::t_item    o_item,
    input  logic                i_pop
);
    syrpf_pkg::t_item r_slot [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_count;
    logic             do_push;

    assign o_full  = (r_count == 2'd2);
    assign o_avail = (r_count != 2'd0);
    assign o_item  = r_slot[r_rp];
    assign do_push = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_count <= r_count + 2'(do_push) - 2'(i_pop);
        end
    end
endmodule

>>> rtl/syrpf_div.sv
// Restoring divider, one quotient bit per cycle, for the coordinate mapping.
// Depends on nothing outside this file.
module syrpf_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [23:0] i_num,
    input  logic [11:0] i_den,
    output logic [23:0] o_quot,
    output logic        o_done
);
    logic [23:0] r_num;
    logic [11:0] r_den;
    logic [11:0] r_rem;
    logic [4:0]  r_cnt;
    logic        r_run;
    logic [12:0] rem_sh;
    logic        take;

    assign rem_sh = {r_rem, r_num[23]};
    assign take   = (rem_sh >= {1'b0, r_den});
    assign o_quot = r_num;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= 12'd0;
        end else if (r_run) begin
            r_num <= {r_num[22:0], take};
            r_rem <= take ? 12'(rem_sh - {1'b0, r_den}) : rem_sh[11:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_cnt  <= 5'd0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= 5'd23;
            end else if (r_run) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_run  <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

>>> rtl/syrpf_back.sv
// Back end: frame store, coordinate mapping, fetch and colour conversion.
// Depends on syrpf_pkg and syrpf_div.
module syrpf_back #(
    parameter int FRAME_HALFWORDS = 1048576
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  syrpf_pkg::t_cfg     i_cfg,
    input  logic                i_avail,
    input  syrpf_pkg::t_item    i_item,
    output logic                o_pop,
    output logic                o_valid,
    output logic [31:0]         o_pixel_word
);
    localparam int ADDR_W = $clog2(FRAME_HALFWORDS);
    typedef logic [ADDR_W-1:0] t_maddr;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_DIVS  = 11'b00000000010,
        S_DIV   = 11'b00000000100,
        S_CLAMP = 11'b00000001000,
        S_ADDR  = 11'b00000010000,
        S_RD0   = 11'b00000100000,
        S_RD1   = 11'b00001000000,
        S_H1    = 11'b00010000000,
        S_MATH  = 11'b00100000000,
        S_PACK  = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } t_state;

    t_state r_state;
    logic [15:0] r_mem [FRAME_HALFWORDS];
    logic [15:0] r_rdata;
    logic [11:0] r_dx, r_dy, r_sx, r_sy;
    logic [25:0] r_line;
    logic [26:0] r_addr1;
    logic        r_oob0, r_oob1;
    logic [15:0] r_h0, r_h1;
    logic signed [19:0] r_sum_r, r_sum_g, r_sum_b;
    logic [15:0] r_rgb;

    logic [11:0] sw1, sh1;
    logic [23:0] qx, qy;
    logic        x_done, y_done;
    logic        div_start;
    logic [26:0] rd_addr;
    logic [26:0] base;
    logic [7:0]  yy, uu, vv;
    logic signed [19:0] c20, d20, e20;
    logic [7:0]  ch_r, ch_g, ch_b;
    logic        wr_ok;

    assign sw1 = syrpf_pkg::at_least_one(i_cfg.source_width);
    assign sh1 = syrpf_pkg::at_least_one(i_cfg.source_height);
    assign div_start = (r_state == S_DIVS);
    assign o_pop = (r_state == S_IDLE) && i_avail;
    assign wr_ok = (23'(i_item.store_address) < 23'(FRAME_HALFWORDS));

    syrpf_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (24'(r_dx) * 24'(sw1)),
        .i_den   (syrpf_pkg::at_least_one(i_cfg.dest_width)),
        .o_quot  (qx),
        .o_done  (x_done)
    );

    syrpf_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (24'(r_dy) * 24'(sh1)),
        .i_den   (syrpf_pkg::at_least_one(i_cfg.dest_height)),
        .o_quot  (qy),
        .o_done  (y_done)
    );

    // Frame store: one write and one registered read per cycle. The first
    // halfword is addressed straight from the line base so that it is
    // ready when the second one is requested.
    assign rd_addr = (r_state == S_RD1) ? r_addr1 : base;

    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.command == syrpf_pkg::CMD_WRITE && wr_ok) begin
            r_mem[t_maddr'(i_item.store_address)] <= i_item.write_data;
        end
        r_rdata <= r_mem[t_maddr'(rd_addr)];
    end

    // The two YUV modes fetch the even-aligned pair.
    assign base = (i_cfg.source_format == syrpf_pkg::FMT_RGB565)
                  ? 27'(r_line) + 27'(r_sx)
                  : 27'(r_line) + 27'({r_sx[11:1], 1'b0});

    always_comb begin
        case (i_cfg.source_format)
            syrpf_pkg::FMT_UYVY: begin
                yy = r_sx[0] ? r_h1[15:8] : r_h0[15:8];
                uu = r_h0[7:0];
                vv = r_h1[7:0];
            end
            default: begin
                yy = r_sx[0] ? r_h1[7:0] : r_h0[7:0];
                uu = r_h0[15:8];
                vv = r_h1[15:8];
            end
        endcase
        c20 = $signed(20'(yy)) - 20'sd16;
        d20 = $signed(20'(uu)) - 20'sd128;
        e20 = $signed(20'(vv)) - 20'sd128;
    end

    assign ch_r = syrpf_pkg::clamp8(r_sum_r);
    assign ch_g = syrpf_pkg::clamp8(r_sum_g);
    assign ch_b = syrpf_pkg::clamp8(r_sum_b);

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_dx <= i_item.dest_x;
                r_dy <= i_item.dest_y;
            end
            S_CLAMP: begin
                r_sx   <= (qx >= 24'(sw1)) ? sw1 - 12'd1 : qx[11:0];
                r_sy   <= (qy >= 24'(sh1)) ? sh1 - 12'd1 : qy[11:0];
            end
            S_ADDR: begin
                r_line <= 26'(r_sy) * 26'(i_cfg.source_stride);
            end
            S_RD0: begin
                r_addr1 <= base + 27'd1;
                r_oob0  <= (base >= 27'(FRAME_HALFWORDS));
                r_oob1  <= (base + 27'd1 >= 27'(FRAME_HALFWORDS));
            end
            S_H1: begin
                r_h0 <= r_oob0 ? 16'd0 : r_h0;
                r_h1 <= r_oob1 ? 16'd0 : r_rdata;
            end
            S_MATH: begin
                r_sum_r <= c20 * 20'sd298 + e20 * 20'sd409 + 20'sd128;
                r_sum_g <= c20 * 20'sd298 - d20 * 20'sd100 - e20 * 20'sd208
                           + 20'sd128;
                r_sum_b <= c20 * 20'sd298 + d20 * 20'sd516 + 20'sd128;
            end
            S_PACK: begin
                case (i_cfg.source_format) inside
                    syrpf_pkg::FMT_RGB565: r_rgb <= r_h0;
                    syrpf_pkg::FMT_YUYV, syrpf_pkg::FMT_UYVY: begin
                        r_rgb <= {ch_r[7:3], ch_g[7:2], ch_b[7:3]};
                    end
                    default: r_rgb <= 16'd0;
                endcase
            end
            default: begin
            end
        endcase
        if (r_state == S_RD1) begin
            r_h0 <= r_rdata;
        end
        if (r_state == S_OUT) begin
            if (i_cfg.dest_bpp_mode == syrpf_pkg::BPP_RGB565) begin
                o_pixel_word <= {16'd0, r_rgb};
            end else begin
                o_pixel_word <= {8'hFF, syrpf_pkg::widen5(r_rgb[15:11]),
                                 syrpf_pkg::widen6(r_rgb[10:5]),
                                 syrpf_pkg::widen5(r_rgb[4:0])};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            o_valid <= (r_state == S_OUT);
            unique case (r_state)
                S_IDLE: begin
                    if (i_avail && i_item.command == syrpf_pkg::CMD_READ) begin
                        r_state <= S_DIVS;
                    end
                end
                S_DIVS:  r_state <= S_DIV;
                S_DIV: begin
                    if (x_done) begin
                        r_state <= S_CLAMP;
                    end
                end
                S_CLAMP: r_state <= S_ADDR;
                S_ADDR:  r_state <= S_RD0;
                S_RD0:   r_state <= S_RD1;
                S_RD1:   r_state <= S_H1;
                S_H1:    r_state <= S_MATH;
                S_MATH:  r_state <= S_PACK;
                S_PACK:  r_state <= S_OUT;
                S_OUT:   r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_valid_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_OUT))
        else $error("result strobe without a finished read");
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        x_done == y_done)
        else $error("coordinate dividers out of step");
    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (i_avail && r_state == S_IDLE))
        else $error("queue popped while the back end is busy");
`endif
endmodule

>>> rtl/scaled_yuv_to_rgb_pixel_fetch_core.sv
// Nearest-neighbour scaling pixel fetch with YUV to RGB565/ARGB8888 output.
// A write reaches the store when the idle back end pops it; a read is strobed
// after the 24-step serial dividers and the clamp, address, fetch, math, pack
// and output states. Reads run one at a time, writes one per cycle when idle;
// a two-entry queue takes further commands. Synchronous active-low reset
// clears control and config state, not the frame store. No stalls out.
module scaled_yuv_to_rgb_pixel_fetch_core #(
    parameter int FRAME_HALFWORDS = 1048576
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_command,
    input  logic [19:0] i_store_address,
    input  logic [15:0] i_write_data,
    input  logic [11:0] i_dest_x,
    input  logic [11:0] i_dest_y,
    output logic        o_valid,
    output logic [31:0] o_pixel_word,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [13:0] i_cfg_wdata
);
    syrpf_pkg::t_cfg  r_cfg;
    syrpf_pkg::t_item in_item, q_item;
    logic             q_avail, q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= syrpf_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                syrpf_pkg::REG_SOURCE_WIDTH:  r_cfg.source_width  <= i_cfg_wdata[11:0];
                syrpf_pkg::REG_SOURCE_HEIGHT: r_cfg.source_height <= i_cfg_wdata[11:0];
                syrpf_pkg::REG_DEST_WIDTH:    r_cfg.dest_width    <= i_cfg_wdata[11:0];
                syrpf_pkg::REG_DEST_HEIGHT:   r_cfg.dest_height   <= i_cfg_wdata[11:0];
                syrpf_pkg::REG_SOURCE_STRIDE: r_cfg.source_stride <= i_cfg_wdata;
                syrpf_pkg::REG_SOURCE_FORMAT: r_cfg.source_format <= i_cfg_wdata[1:0];
                syrpf_pkg::REG_DEST_BPP_MODE: r_cfg.dest_bpp_mode <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign in_item = '{
        command:       i_command,
        store_address: i_store_address,
        write_data:    i_write_data,
        dest_x:        i_dest_x,
        dest_y:        i_dest_y
    };

    syrpf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (start),
        .i_item  (in_item),
        .o_full  (busy),
        .o_avail (q_avail),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    syrpf_back #(
        .FRAME_HALFWORDS (FRAME_HALFWORDS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_avail      (q_avail),
        .i_item       (q_item),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .o_pixel_word (o_pixel_word)
    );
endmodule

>>> bench/scaled_yuv_to_rgb_pixel_fetch_core_tb.sv
// Self-checking bench for the scaled YUV to RGB pixel fetch core.
// Drives writes and reads from a queue and checks each pixel against its own prediction.
// Depends on syrpf_pkg and the core.
`timescale 1ns / 1ps

module scaled_yuv_to_rgb_pixel_fetch_core_tb;

    localparam int STORE_SIZE = 1048576;
    localparam int SETTLE_CYCLES = 48;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_command;
    logic [19:0] i_store_address;
    logic [15:0] i_write_data;
    logic [11:0] i_dest_x;
    logic [11:0] i_dest_y;
    logic        o_valid;
    logic [31:0] o_pixel_word;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [13:0] i_cfg_wdata;

    syrpf_pkg::t_item pending_items[$];
    syrpf_pkg::t_item cur_item;
    logic [31:0]  pixel_queue[$];
    logic [15:0]  frame_copy[int];
    bit           prepared[int];
    syrpf_pkg::t_cfg cfg_model;
    int           sender_idle_pct;
    int           error_count;
    int           read_count;
    int           write_count;
    int           push_count;

    scaled_yuv_to_rgb_pixel_fetch_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_store_address (i_store_address),
        .i_write_data    (i_write_data),
        .i_dest_x        (i_dest_x),
        .i_dest_y        (i_dest_y),
        .o_valid         (o_valid),
        .o_pixel_word    (o_pixel_word),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int nonzero(input logic [11:0] v);
        return (v == 12'd0) ? 1 : int'(v);
    endfunction

    function automatic longint scale_coord(input logic [11:0] d, input logic [11:0] src,
                                           input logic [11:0] dst);
        longint q;
        q = (longint'(d) * nonzero(src)) / nonzero(dst);
        if (q >= nonzero(src)) begin
            q = nonzero(src) - 1;
        end
        return q;
    endfunction

    function automatic logic [15:0] store_half(input longint addr);
        if (addr >= STORE_SIZE || !frame_copy.exists(int'(addr))) begin
            return 16'h0;
        end
        return frame_copy[int'(addr)];
    endfunction

    function automatic int channel(input int sum);
        if (sum < 0) begin
            return 0;
        end
        return ((sum >>> 8) > 255) ? 255 : (sum >>> 8);
    endfunction

    function automatic logic [15:0] yuv_to_565(input int y, input int u, input int v);
        int c, d, e, r, g, b;
        c = y - 16;
        d = u - 128;
        e = v - 128;
        r = channel(298 * c + 409 * e + 128);
        g = channel(298 * c - 100 * d - 208 * e + 128);
        b = channel(298 * c + 516 * d + 128);
        return 16'(((r & 'hF8) << 8) | ((g & 'hFC) << 3) | (b >> 3));
    endfunction

    function automatic logic [31:0] predict_pixel(input logic [11:0] x, input logic [11:0] y);
        longint sx, sy, line, pair;
        logic [15:0] h0, h1, rgb;
        int r8, g8, b8;
        sx = scale_coord(x, cfg_model.source_width, cfg_model.dest_width);
        sy = scale_coord(y, cfg_model.source_height, cfg_model.dest_height);
        line = sy * cfg_model.source_stride;
        pair = line + (sx & ~longint'(1));
        h0 = store_half(pair);
        h1 = store_half(pair + 1);
        case (cfg_model.source_format)
            syrpf_pkg::FMT_RGB565: rgb = store_half(line + sx);
            syrpf_pkg::FMT_YUYV:
                rgb = yuv_to_565(sx[0] ? h1[7:0] : h0[7:0], h0[15:8], h1[15:8]);
            syrpf_pkg::FMT_UYVY:
                rgb = yuv_to_565(sx[0] ? h1[15:8] : h0[15:8], h0[7:0], h1[7:0]);
            default:    rgb = 16'h0;
        endcase
        if (cfg_model.dest_bpp_mode == syrpf_pkg::BPP_RGB565) begin
            return {16'h0, rgb};
        end
        r8 = (int'(rgb[15:11]) * 255) / 31;
        g8 = (int'(rgb[10:5]) * 255) / 63;
        b8 = (int'(rgb[4:0]) * 255) / 31;
        return {8'hFF, 8'(r8), 8'(g8), 8'(b8)};
    endfunction

    // Driver: a transfer happens at an edge with start high and busy low.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                if (cur_item.command == syrpf_pkg::CMD_WRITE) begin
                    frame_copy[int'(cur_item.store_address)] = cur_item.write_data;
                    write_count++;
                end else begin
                    pixel_queue.push_back(predict_pixel(cur_item.dest_x, cur_item.dest_y));
                    read_count++;
                end
            end
            if (!start || !busy) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                    cur_item = pending_items.pop_front();
                    i_command       <= cur_item.command;
                    i_store_address <= cur_item.store_address;
                    i_write_data    <= cur_item.write_data;
                    i_dest_x        <= cur_item.dest_x;
                    i_dest_y        <= cur_item.dest_y;
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: each strobed result is taken in the cycle it appears.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pixel_queue.size() == 0) begin
                $display("%0t: unexpected pixel, expected none, actual %08h",
                         $time, o_pixel_word);
                error_count++;
            end else begin
                logic [31:0] want;
                want = pixel_queue.pop_front();
                if (o_pixel_word !== want) begin
                    $display("%0t: pixel_word mismatch, expected %08h, actual %08h",
                             $time, want, o_pixel_word);
                    error_count++;
                end
            end
        end
    end

    task automatic push_write(input logic [19:0] addr, input logic [15:0] data);
        syrpf_pkg::t_item it;
        it = '0;
        it.command = syrpf_pkg::CMD_WRITE;
        it.store_address = addr;
        it.write_data = data;
        it.dest_x = 12'($urandom);
        it.dest_y = 12'($urandom);
        prepared[int'(addr)] = 1'b1;
        pending_items.push_back(it);
        push_count++;
    endtask

    task automatic fill_if_needed(input longint addr);
        if (addr < STORE_SIZE && !prepared.exists(int'(addr))) begin
            push_write(20'(addr), 16'($urandom));
        end
    endtask

    // Each in-store halfword the read's result depends on is written beforehand.
    task automatic push_read(input logic [11:0] x, input logic [11:0] y);
        syrpf_pkg::t_item it;
        longint sx, sy, line;
        sx = scale_coord(x, cfg_model.source_width, cfg_model.dest_width);
        sy = scale_coord(y, cfg_model.source_height, cfg_model.dest_height);
        line = sy * cfg_model.source_stride;
        if (cfg_model.source_format == syrpf_pkg::FMT_RGB565) begin
            fill_if_needed(line + sx);
        end else if (cfg_model.source_format == syrpf_pkg::FMT_YUYV ||
                     cfg_model.source_format == syrpf_pkg::FMT_UYVY) begin
            fill_if_needed(line + (sx & ~longint'(1)));
            fill_if_needed(line + (sx & ~longint'(1)) + 1);
        end
        it = '0;
        it.command = syrpf_pkg::CMD_READ;
        it.store_address = 20'($urandom);
        it.write_data = 16'($urandom);
        it.dest_x = x;
        it.dest_y = y;
        pending_items.push_back(it);
        push_count++;
    endtask

    task automatic drain;
        while (pending_items.size() > 0 || start || pixel_queue.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [2:0] index, input int value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wdata <= 14'(value);
        case (index)
            syrpf_pkg::REG_SOURCE_WIDTH:  cfg_model.source_width  = 12'(value);
            syrpf_pkg::REG_SOURCE_HEIGHT: cfg_model.source_height = 12'(value);
            syrpf_pkg::REG_DEST_WIDTH:    cfg_model.dest_width    = 12'(value);
            syrpf_pkg::REG_DEST_HEIGHT:   cfg_model.dest_height   = 12'(value);
            syrpf_pkg::REG_SOURCE_STRIDE: cfg_model.source_stride = 14'(value);
            syrpf_pkg::REG_SOURCE_FORMAT: cfg_model.source_format = 2'(value);
            syrpf_pkg::REG_DEST_BPP_MODE: cfg_model.dest_bpp_mode = 1'(value);
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic int pick_size(input int p);
        case ($urandom_range(5))
            0: return (p == 3) ? 0 : 1;
            1: return 4095;
            2: return $urandom_range(1, 4095);
            default: return $urandom_range(1, 64);
        endcase
    endfunction

    // The count covers every item sent, the filling writes included.
    task automatic random_reads(input int count);
        int n;
        int first;
        logic [11:0] x, y;
        n = 0;
        first = push_count;
        while (push_count - first < count) begin
            if ($urandom_range(4) == 0) begin
                push_write(20'($urandom), 16'($urandom));
            end else begin
                if ($urandom_range(4) == 0) begin
                    x = 12'($urandom);
                    y = 12'($urandom);
                end else begin
                    x = 12'($urandom_range(nonzero(cfg_model.dest_width) - 1));
                    y = 12'($urandom_range(nonzero(cfg_model.dest_height) - 1));
                end
                push_read(x, y);
            end
            n++;
            // Occasionally hold the sender until every pixel has come back.
            if (n % 60 == 0) begin
                drain;
            end
        end
    endtask

    initial begin
        error_count = 0;
        read_count = 0;
        write_count = 0;
        push_count = 0;
        sender_idle_pct = 23;
        cfg_model = syrpf_pkg::CFG_RESET;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_command = syrpf_pkg::CMD_WRITE;
        i_store_address = '0;
        i_write_data = '0;
        i_dest_x = '0;
        i_dest_y = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset settings: store extremes and coordinate corners.
        push_write(20'h00000, 16'h0000);
        push_write(20'hFFFFF, 16'hFFFF);
        push_write(20'h00001, 16'hFFFF);
        push_write(20'hFFFFE, 16'h0000);
        push_write(20'h00002, 16'h80FF);
        push_write(20'h00003, 16'h10EB);
        push_read(12'd0, 12'd0);
        push_read(12'd1, 12'd0);
        push_read(12'd2, 12'd0);
        push_read(12'd3, 12'd0);
        push_read(12'd1023, 12'd599);
        push_read(12'd4095, 12'd4095);
        push_read(12'd4095, 12'd0);
        push_read(12'd0, 12'd4095);
        drain;

        for (int p = 1; p <= 9; p++) begin
            sender_idle_pct = (p <= 3) ? 23 : (p <= 6) ? 86 : 0;
            set_reg(syrpf_pkg::REG_SOURCE_WIDTH, pick_size(p));
            set_reg(syrpf_pkg::REG_SOURCE_HEIGHT, (p == 8) ? 4095 : pick_size(p));
            set_reg(syrpf_pkg::REG_DEST_WIDTH, pick_size(p));
            set_reg(syrpf_pkg::REG_DEST_HEIGHT, pick_size(p));
            // Zero stride folds every line together; the widest runs reads off the store.
            set_reg(syrpf_pkg::REG_SOURCE_STRIDE, (p == 2) ? 0 : (p == 8) ? 16383
                                                  : $urandom_range(1, 2048));
            set_reg(syrpf_pkg::REG_SOURCE_FORMAT, p % 4);
            set_reg(syrpf_pkg::REG_DEST_BPP_MODE, (p / 4) % 2);
            if (p == 8) begin
                push_read(12'd4095, 12'd4095);
                push_read(12'd0, 12'd4095);
            end
            random_reads(210);
            drain;
        end

        $display("Covered %0d writes and %0d checked reads over all formats and both",
                 write_count, read_count);
        $display("output modes, with size, stride and coordinate extremes.");
        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
